@@ design/tks_pkg.sv @@
// ----------------------------------------------------------------------------
// tks_pkg
// Shared types and constants of the top-k score select unit.
// ----------------------------------------------------------------------------
package tks_pkg;

    localparam int KEEP_W     = 7;
    localparam int KEEP_RESET = 64;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DRAIN  = 1'b1;

    typedef struct packed {
        logic               command;
        logic [31:0]        node_a;
        logic [31:0]        node_b;
        logic signed [31:0] score;
    } in_item_t;

    typedef struct packed {
        logic [31:0]        node_a_res;
        logic [31:0]        node_b_res;
        logic signed [31:0] score_res;
        logic               last;
    } out_item_t;

    typedef struct packed {
        logic signed [31:0] score;
        logic [31:0]        node_a;
        logic [31:0]        node_b;
    } entry_t;

    typedef struct packed {
        logic      valid;
        out_item_t item;
    } out_push_t;

endpackage

@@ design/tks_ram.sv @@
// ----------------------------------------------------------------------------
// tks_ram
// Edge store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tks_ram
    import tks_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  entry_t        wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output entry_t        rdata
);

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/tks_out_reg.sv @@
// ----------------------------------------------------------------------------
// tks_out_reg
// Result register: holds one transfer until the receiver takes it.
// ----------------------------------------------------------------------------
module tks_out_reg
    import tks_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  out_push_t push,
    output logic      space,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    logic      valid_reg;
    logic      valid_next;
    out_item_t item_reg;
    out_item_t item_next;

    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (m_ready) begin
            valid_next = 1'b0;
        end
        if (push.valid) begin
            valid_next = 1'b1;
            item_next  = push.item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
    end

    assign space   = !valid_reg || m_ready;
    assign m_valid = valid_reg;
    assign m_item  = item_reg;

    // a push never lands on a result that is still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        push.valid |-> (!valid_reg || m_ready))
        else $error("result overwritten before transfer");

endmodule

@@ design/top_k_score_select_unit.sv @@
// ----------------------------------------------------------------------------
// top_k_score_select_unit
// Keeps the keep_count highest scoring edges, emits them in ascending order.
// ----------------------------------------------------------------------------
// Input channel s_valid/s_ready/s_item carries insert and drain commands;
// s_ready is high only while no command is in progress. Result channel
// m_valid/m_ready/m_item carries the edges of a drain, lowest score first,
// with last set on the final one. cfg_wr_en/cfg_wr_data write keep_count.
// Edges sit in a circular store kept sorted by score; the lowest entry is
// dropped by advancing the ring base.
// Insert: each held edge with a higher score is moved up one slot by a read
// and write of the store, then the new edge fills the freed slot; into an
// empty set it is written directly. An insert into a full set first reads the
// lowest entry and evicts it if the new score is equal or higher, else the
// new edge is dropped. Drain: one read of the single read port per result,
// each after the last is pushed; a drain of an empty set gives no result.
// Reset empties the set and sets keep_count to 64. A stalled receiver
// holds the result register and the drain waits; once the last result is
// in that register, the next command is taken.
// ----------------------------------------------------------------------------
module top_k_score_select_unit
    import tks_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_item_t          s_item,
    output logic              m_valid,
    input  logic              m_ready,
    output out_item_t         m_item,
    input  logic              cfg_wr_en,
    input  logic [KEEP_W-1:0] cfg_wr_data
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int MW = (CW > KEEP_W) ? CW : KEEP_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ_MIN,
        ST_CMP_MIN,
        ST_PLACE,
        ST_SHIFT,
        ST_FINAL,
        ST_DRAIN
    } state_t;

    state_t            state_reg, state_next;
    in_item_t          item_reg, item_next;
    logic [KEEP_W-1:0] keep_reg, keep_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [AW-1:0]     base_reg, base_next;
    logic [CW-1:0]     pos_reg, pos_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic              rd_pend_reg, rd_pend_next;
    logic              last_pend_reg, last_pend_next;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    entry_t        mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    entry_t        mem_rdata;
    entry_t        item_entry;

    out_push_t push;
    logic      out_space;

    logic [MW-1:0] keep_ext;
    logic [CW-1:0] k_eff;
    logic [AW-1:0] base_inc;

    function automatic logic [AW-1:0] phys(input logic [AW-1:0] b,
                                           input logic [CW-1:0] l);
        logic [AW:0] sum;
        sum = {1'b0, b} + {1'b0, l[AW-1:0]};
        if (sum >= (AW+1)'(CAPACITY)) begin
            sum = sum - (AW+1)'(CAPACITY);
        end
        return sum[AW-1:0];
    endfunction

    always_comb begin
        keep_ext = MW'(keep_reg);
        if (keep_reg == '0) begin
            k_eff = CW'(1);
        end else if (keep_ext > MW'(CAPACITY)) begin
            k_eff = CW'(CAPACITY);
        end else begin
            k_eff = keep_ext[CW-1:0];
        end
    end

    assign base_inc   = (base_reg == AW'(CAPACITY - 1)) ? '0 : base_reg + AW'(1);
    assign item_entry = '{score: item_reg.score, node_a: item_reg.node_a,
                          node_b: item_reg.node_b};
    assign s_ready    = (state_reg == ST_IDLE);

    always_comb begin
        state_next     = state_reg;
        item_next      = item_reg;
        keep_next      = keep_reg;
        count_next     = count_reg;
        base_next      = base_reg;
        pos_next       = pos_reg;
        idx_next       = idx_reg;
        rd_pend_next   = rd_pend_reg;
        last_pend_next = last_pend_reg;
        mem_we         = 1'b0;
        mem_waddr      = phys(base_reg, pos_reg);
        mem_wdata      = item_entry;
        mem_re         = 1'b0;
        mem_raddr      = base_reg;
        push.valid     = 1'b0;
        push.item      = '{node_a_res: mem_rdata.node_a, node_b_res: mem_rdata.node_b,
                           score_res: mem_rdata.score, last: last_pend_reg};

        if (cfg_wr_en) begin
            keep_next = cfg_wr_data;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    item_next = s_item;
                    if (s_item.command == CMD_DRAIN) begin
                        idx_next = '0;
                        if (count_reg != '0) begin
                            state_next = ST_DRAIN;
                        end
                    end else if (count_reg < k_eff) begin
                        state_next = ST_PLACE;
                    end else begin
                        state_next = ST_READ_MIN;
                    end
                end
            end
            ST_READ_MIN: begin
                mem_re     = 1'b1;
                mem_raddr  = base_reg;
                state_next = ST_CMP_MIN;
            end
            ST_CMP_MIN: begin
                // evict the lowest entry, else drop the new edge
                if (item_reg.score >= mem_rdata.score) begin
                    base_next  = base_inc;
                    count_next = count_reg - CW'(1);
                    state_next = ST_PLACE;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_PLACE: begin
                pos_next = count_reg;
                if (count_reg == '0) begin
                    mem_we     = 1'b1;
                    mem_waddr  = base_reg;
                    count_next = count_reg + CW'(1);
                    state_next = ST_IDLE;
                end else begin
                    mem_re     = 1'b1;
                    mem_raddr  = phys(base_reg, count_reg - CW'(1));
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                mem_we    = 1'b1;
                mem_waddr = phys(base_reg, pos_reg);
                if (mem_rdata.score > item_reg.score) begin
                    // move the higher entry up one slot
                    mem_wdata = mem_rdata;
                    pos_next  = pos_reg - CW'(1);
                    if (pos_reg == CW'(1)) begin
                        state_next = ST_FINAL;
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = phys(base_reg, pos_reg - CW'(2));
                    end
                end else begin
                    count_next = count_reg + CW'(1);
                    state_next = ST_IDLE;
                end
            end
            ST_FINAL: begin
                mem_we     = 1'b1;
                mem_waddr  = phys(base_reg, pos_reg);
                count_next = count_reg + CW'(1);
                state_next = ST_IDLE;
            end
            ST_DRAIN: begin
                if (rd_pend_reg) begin
                    push.valid   = 1'b1;
                    rd_pend_next = 1'b0;
                    if (last_pend_reg) begin
                        count_next = '0;
                        base_next  = '0;
                        state_next = ST_IDLE;
                    end
                end else if (out_space && (idx_reg != count_reg)) begin
                    mem_re         = 1'b1;
                    mem_raddr      = phys(base_reg, idx_reg);
                    rd_pend_next   = 1'b1;
                    last_pend_next = (idx_reg == count_reg - CW'(1));
                    idx_next       = idx_reg + CW'(1);
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            keep_reg      <= KEEP_W'(KEEP_RESET);
            count_reg     <= '0;
            base_reg      <= '0;
            pos_reg       <= '0;
            idx_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            last_pend_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            keep_reg      <= keep_next;
            count_reg     <= count_next;
            base_reg      <= base_next;
            pos_reg       <= pos_next;
            idx_reg       <= idx_next;
            rd_pend_reg   <= rd_pend_next;
            last_pend_reg <= last_pend_next;
        end
        item_reg <= item_next;
    end

    tks_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    tks_out_reg u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .space   (out_space),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("held count beyond capacity");

    a_base_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        base_reg <= AW'(CAPACITY - 1))
        else $error("ring base out of range");

    a_shift_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SHIFT |-> pos_reg != '0)
        else $error("shift at slot zero");

    a_pend_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_pend_reg |-> !m_valid)
        else $error("read in flight with result register occupied");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(rd_pend_reg))
        else $error("result without a store read");

endmodule
